[hw/rtl/cbe_pkg.sv]
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, codes and types of the cubic B-spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbe_pkg;

  localparam int FRAC_BITS  = 16;              // fraction bits of param_u
  localparam int INV_FRAC   = 16;              // fraction bits of inv_dt
  localparam int COORD_W    = 32;
  localparam int U_W        = 22;
  localparam int SEG_W      = U_W - FRAC_BITS; // segment index width
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int INV_W      = 24;
  localparam int MIN_COUNT  = 4;

  // basis weights reach 4*T, signed
  localparam int WGT_W      = FRAC_BITS + 5;
  localparam int PROD_W     = COORD_W + WGT_W;
  localparam int SUM_W      = PROD_W + 2;

  // register stages from input transfer to output register
  localparam int PIPE_DEPTH = 10;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 128;
  localparam int ADDR_W     = 3;
  localparam int APB_W      = 32;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // register select is paddr[2]
  localparam logic REG_CONTROL_COUNT = 1'b0;
  localparam logic REG_INV_DT        = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WGT_W-1:0]   wgt_t;
  typedef logic [FRAC_BITS-1:0]      frac_t;

  typedef struct packed {
    wgt_t [3:0] w;   // position weights, scaled by 6T
    wgt_t [3:0] d;   // derivative weights, scaled by 2T
  } weights_t;

endpackage

`default_nettype wire

[hw/rtl/cbe_ram.sv]
// ----------------------------------------------------------------------------
// cbe_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cbe_basis.sv]
// ----------------------------------------------------------------------------
// cbe_basis
// Three-stage basis generator: t^2, t^3, then position and derivative weights.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_basis import cbe_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  frac_t    t_in,
  output weights_t wts
);

  localparam int CALC_W = WGT_W + 3;
  localparam logic signed [CALC_W-1:0] ONE = CALC_W'(1 << FRAC_BITS);

  frac_t t_a, t2_a;
  frac_t t_b, t2_b, t3_b;
  logic [2*FRAC_BITS-1:0] sq, cube;
  logic signed [CALC_W-1:0] tv, t2v, t3v;
  weights_t wts_next;

  assign sq   = {{FRAC_BITS{1'b0}}, t_in} * {{FRAC_BITS{1'b0}}, t_in};
  assign cube = {{FRAC_BITS{1'b0}}, t2_a} * {{FRAC_BITS{1'b0}}, t_a};

  assign tv  = $signed({{(CALC_W-FRAC_BITS){1'b0}}, t_b});
  assign t2v = $signed({{(CALC_W-FRAC_BITS){1'b0}}, t2_b});
  assign t3v = $signed({{(CALC_W-FRAC_BITS){1'b0}}, t3_b});

  always_comb begin
    wts_next.w[0] = WGT_W'(ONE - 3 * tv + 3 * t2v - t3v);
    wts_next.w[1] = WGT_W'(4 * ONE - 6 * t2v + 3 * t3v);
    wts_next.w[2] = WGT_W'(ONE + 3 * tv + 3 * t2v - 3 * t3v);
    wts_next.w[3] = WGT_W'(t3v);
    wts_next.d[0] = WGT_W'(-(ONE - 2 * tv + t2v));
    wts_next.d[1] = WGT_W'(3 * t2v - 4 * tv);
    wts_next.d[2] = WGT_W'(ONE + 2 * tv - 3 * t2v);
    wts_next.d[3] = WGT_W'(t2v);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_a  <= t_in;
      t2_a <= sq[2*FRAC_BITS-1:FRAC_BITS];
      t_b  <= t_a;
      t2_b <= t2_a;
      t3_b <= cube[2*FRAC_BITS-1:FRAC_BITS];
      wts  <= wts_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cbe_axis.sv]
// ----------------------------------------------------------------------------
// cbe_axis
// One coordinate axis: weighted sums, rounding, divide by three, velocity
// scaling and saturation, cut into stages S3 to S10.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_axis import cbe_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  coord_t           c_in [4],   // control points, stage S2
  input  weights_t         wts,        // weights, stage S4
  input  logic [INV_W-1:0] inv_dt,
  output coord_t           pos,
  output coord_t           vel
);

  localparam int SH    = FRAC_BITS + 1;          // 2T = 2^SH
  localparam int B_W   = SUM_W - SH;
  localparam int X_W   = COORD_W + 2;
  localparam int XL_W  = 17;
  localparam int XH_W  = X_W - XL_W;
  localparam int QH_W  = XH_W - 1;
  localparam int Y_W   = XL_W + 2;
  localparam int Q_W   = COORD_W + 1;
  localparam int RECIP_H = ((1 << (XH_W + 1)) + 2) / 3;
  localparam int RECIP_L = ((1 << (Y_W + 1)) + 2) / 3;
  localparam int DL_W  = 18;
  localparam int DH_W  = B_W - DL_W;
  localparam int PH_W  = DH_W + INV_W + 1;
  localparam int PL_W  = DL_W + INV_W;
  localparam int VS_W  = 64;
  localparam int VR_W  = VS_W - INV_FRAC;

  localparam logic signed [SUM_W-1:0] POS_HALF = SUM_W'(64'sd3 <<< FRAC_BITS);
  localparam logic signed [SUM_W-1:0] DER_HALF = SUM_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [B_W-1:0]   B_LIM    = B_W'(64'sd3 <<< (COORD_W - 1));
  localparam logic signed [B_W-1:0]   B_LIM_N  = -B_LIM;
  localparam logic signed [VS_W-1:0]  VEL_HALF = VS_W'(64'sd1 <<< (INV_FRAC - 1));
  localparam logic [XH_W-1:0]         RH_K     = XH_W'(RECIP_H);
  localparam logic [Y_W-1:0]          RL_K     = Y_W'(RECIP_L);
  localparam coord_t                  SAT_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t                  SAT_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

  coord_t c_s3 [4];
  coord_t c_s4 [4];
  logic signed [PROD_W-1:0] pw [4];
  logic signed [PROD_W-1:0] pd [4];
  logic signed [SUM_W-1:0]  ps, ds;
  logic signed [B_W-1:0]    pb, pb_clamp, dv;
  logic [X_W-1:0]           x_s7;
  logic signed [B_W-1:0]    dv_s7;
  logic [2*XH_W-1:0]        prod_h;
  logic [QH_W-1:0]          qh_s8, qh_s9;
  logic [XH_W-1:0]          xh_s8;
  logic [XL_W-1:0]          xl_s8, ql_s9;
  logic signed [PH_W-1:0]   ph_s8;
  logic [PL_W-1:0]          pl_s8;
  logic [1:0]               rh;
  logic [Y_W-1:0]           y;
  logic [2*Y_W-1:0]         prod_l;
  logic signed [VS_W-1:0]   vs;
  logic signed [VR_W-1:0]   vr_s9;
  logic [Q_W-1:0]           q;
  logic                     v_hi, v_lo;

  // S7: round by 6T as floor(floor((ps + 3T) / 2T) / 3); clamp keeps the
  // saturated result and makes the dividend non-negative
  assign pb = B_W'((ps + POS_HALF) >>> SH);
  assign dv = B_W'((ds + DER_HALF) >>> SH);

  always_comb begin
    if (pb > B_LIM) begin
      pb_clamp = B_LIM;
    end else if (pb < B_LIM_N) begin
      pb_clamp = B_LIM_N;
    end else begin
      pb_clamp = pb;
    end
  end

  // S8: high digit divided by three
  assign prod_h = x_s7[X_W-1:XL_W] * RH_K;

  // S9: remainder joins the low digit, divide again
  assign rh     = 2'(32'(xh_s8) - 32'(qh_s8) * 3);
  assign y      = {rh, xl_s8};
  assign prod_l = y * RL_K;
  assign vs     = (VS_W'(ph_s8) <<< DL_W) + VS_W'($signed({1'b0, pl_s8})) + VEL_HALF;

  // S10: quotient is offset by 2^31
  assign q    = Q_W'({qh_s9, {XL_W{1'b0}}}) + Q_W'(ql_s9);
  assign v_hi = !vr_s9[VR_W-1] && (|vr_s9[VR_W-2:COORD_W-1]);
  assign v_lo = vr_s9[VR_W-1] && !(&vr_s9[VR_W-2:COORD_W-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        c_s3[k] <= c_in[k];
        c_s4[k] <= c_s3[k];
        pw[k]   <= PROD_W'(c_s4[k]) * PROD_W'($signed(wts.w[k]));
        pd[k]   <= PROD_W'(c_s4[k]) * PROD_W'($signed(wts.d[k]));
      end
      ps <= SUM_W'(pw[0]) + SUM_W'(pw[1]) + SUM_W'(pw[2]) + SUM_W'(pw[3]);
      ds <= SUM_W'(pd[0]) + SUM_W'(pd[1]) + SUM_W'(pd[2]) + SUM_W'(pd[3]);

      x_s7  <= X_W'(pb_clamp - B_LIM_N);
      dv_s7 <= dv;

      qh_s8 <= prod_h[2*XH_W-1:XH_W+1];
      xh_s8 <= x_s7[X_W-1:XL_W];
      xl_s8 <= x_s7[XL_W-1:0];
      ph_s8 <= PH_W'($signed(dv_s7[B_W-1:DL_W])) * PH_W'($signed({1'b0, inv_dt}));
      pl_s8 <= PL_W'(dv_s7[DL_W-1:0]) * PL_W'(inv_dt);

      qh_s9 <= qh_s8;
      ql_s9 <= prod_l[Y_W+1+:XL_W];
      vr_s9 <= VR_W'(vs >>> INV_FRAC);

      pos <= q[COORD_W] ? SAT_MAX : {~q[COORD_W-1], q[COORD_W-2:0]};
      vel <= v_hi ? SAT_MAX : (v_lo ? SAT_MIN : vr_s9[COORD_W-1:0]);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cubic_bspline_evaluator_core.sv]
// ----------------------------------------------------------------------------
// cubic_bspline_evaluator_core
// Uniform cubic B-spline evaluator over a memory of 2D control points.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tuser = cmd, s_tdata = point + u
//  m_*       out  m_tvalid / m_tready    m_tdata = pos_x, pos_y, vel_x, vel_y
//  APB       in   psel/penable/pready    control_count @0x0, inv_dt @0x4
//
//  One item per cycle while the output register is empty or taken; an evaluate
//  result passes through a pipeline of ten register stages.
//  Point writes go to four RAM copies so the four taps read in one cycle.
//  The whole pipeline holds while the output register is full and not taken.
//  Reset clears the valid bits and loads control_count 4 and inv_dt 65536;
//  point memory is undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bspline_evaluator_core import cbe_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // point_index, point_x, point_y, param_u, pad
  input  logic                  s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int LIM_W = CNT_W + FRAC_BITS;

  logic [CNT_W-1:0]      control_count;
  logic [INV_W-1:0]      inv_dt;
  logic                  cfg_wr;
  logic                  adv, in_xfer, wr_en;
  logic [IDX_W-1:0]      in_index;
  logic [COORD_W-1:0]    in_x, in_y;
  logic [U_W-1:0]        in_u;
  logic [CNT_W-1:0]      cnt;
  logic [LIM_W-1:0]      u_lim, u_c;
  logic [SEG_W-1:0]      i_s1;
  frac_t                 t_s1;
  logic [PIPE_DEPTH-1:0] vld;
  logic [2*COORD_W-1:0]  rd_data [4];
  coord_t                c_x [4];
  coord_t                c_y [4];
  weights_t              wts;
  coord_t                pos_x, pos_y, vel_x, vel_y;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_count <= CNT_W'(4);
      inv_dt        <= INV_W'(65536);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_CONTROL_COUNT: control_count <= pwdata[CNT_W-1:0];
        REG_INV_DT:        inv_dt        <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CONTROL_COUNT: prdata = APB_W'(control_count);
      REG_INV_DT:        prdata = APB_W'(inv_dt);
      default:           prdata = '0;
    endcase
  end

  // input side
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign in_xfer  = s_tvalid && s_tready;
  assign in_index = s_tdata[IDX_W-1:0];
  assign in_x     = s_tdata[IDX_W+:COORD_W];
  assign in_y     = s_tdata[IDX_W+COORD_W+:COORD_W];
  assign in_u     = s_tdata[IDX_W+2*COORD_W+:U_W];
  assign wr_en    = in_xfer && (s_tuser == CMD_WRITE) && (32'(in_index) < 32'(MAX_POINTS));

  // clamp u below segments * T
  always_comb begin
    if (32'(control_count) > 32'(MAX_POINTS)) begin
      cnt = CNT_W'(MAX_POINTS);
    end else begin
      cnt = control_count;
    end
    if (cnt < CNT_W'(MIN_COUNT)) begin
      cnt = CNT_W'(MIN_COUNT);
    end
    u_lim = {cnt - CNT_W'(MIN_COUNT), {FRAC_BITS{1'b1}}};
    u_c   = (LIM_W'(in_u) > u_lim) ? u_lim : LIM_W'(in_u);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_s1 <= u_c[FRAC_BITS+:SEG_W];
      t_s1 <= u_c[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_DEPTH-2:0], in_xfer && (s_tuser == CMD_EVAL)};
    end
  end

  // one RAM copy per tap: bank k reads point i + k
  for (genvar k = 0; k < 4; k++) begin : g_bank
    cbe_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (MAX_POINTS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (AW'(in_index)),
      .wr_data ({in_y, in_x}),
      .rd_en   (adv),
      .rd_addr (AW'({1'b0, i_s1} + (SEG_W + 1)'(k))),
      .rd_data (rd_data[k])
    );
    assign c_x[k] = $signed(rd_data[k][COORD_W-1:0]);
    assign c_y[k] = $signed(rd_data[k][2*COORD_W-1:COORD_W]);
  end

  cbe_basis u_basis (
    .clk  (clk),
    .en   (adv),
    .t_in (t_s1),
    .wts  (wts)
  );

  cbe_axis u_axis_x (
    .clk    (clk),
    .en     (adv),
    .c_in   (c_x),
    .wts    (wts),
    .inv_dt (inv_dt),
    .pos    (pos_x),
    .vel    (vel_x)
  );

  cbe_axis u_axis_y (
    .clk    (clk),
    .en     (adv),
    .c_in   (c_y),
    .wts    (wts),
    .inv_dt (inv_dt),
    .pos    (pos_y),
    .vel    (vel_y)
  );

  assign m_tvalid = vld[PIPE_DEPTH-1];
  assign m_tdata  = {vel_y, vel_x, pos_y, pos_x};

endmodule

`default_nettype wire

[hw/rtl/cbe_checker.sv]
// ----------------------------------------------------------------------------
// cbe_checker
// Port-level checks of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_checker import cbe_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [ADDR_W-1:0]     paddr,
  input logic [APB_W-1:0]      pwdata,
  input logic [APB_W-1:0]      prdata,
  input logic                  pready
);

  // a result waiting for transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // an empty output never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result present right after reset");

  // a count write reads back at once
  a_count_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[2] == REG_CONTROL_COUNT) |=>
      (paddr[2] == REG_INV_DT) ||
      (prdata == {{(APB_W-CNT_W){1'b0}}, $past(pwdata[CNT_W-1:0])}))
    else $error("control_count readback mismatch");

endmodule

bind cubic_bspline_evaluator_core cbe_checker u_cbe_checker (.*);

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cubic B-spline evaluator core. It streams point
// writes and curve queries with random bursts and output stalls, and changes
// the control-point count and the inverse time step between drained phases.
// An in-bench fixed-point predictor computes each position and velocity, and
// every output transfer is checked against the oldest predicted sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import cbe_pkg::*;

  localparam int     POINT_SLOTS = 64;
  localparam int     PAD_W       = IN_DATA_W - IDX_W - 2 * COORD_W - U_W;
  localparam int     CYCLE_LIMIT = 400000;
  localparam longint COORD_MAX   = 64'sd2147483647;
  localparam longint COORD_MIN   = -64'sd2147483648;

  localparam logic [ADDR_W-1:0] ADDR_CONTROL_COUNT = {REG_CONTROL_COUNT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_INV_DT        = {REG_INV_DT, 2'b00};

  typedef struct {
    logic                 cmd;
    logic [IDX_W-1:0]     slot;
    coord_t               x;
    coord_t               y;
    logic [U_W-1:0]       u;
  } spline_cmd_t;

  // packed so that pos_x lands in the lowest bits, as on m_tdata
  typedef struct packed {
    coord_t vel_y;
    coord_t vel_x;
    coord_t pos_y;
    coord_t pos_x;
  } curve_sample_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // point_index, point_x, point_y, param_u, pad
  logic                  s_tuser = 1'b0; // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // pos_x, pos_y, vel_x, vel_y
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [APB_W-1:0]      pwdata = '0;
  logic [APB_W-1:0]      prdata;
  logic                  pready;

  cubic_bspline_evaluator_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  coord_t            pt_x_mem [POINT_SLOTS];
  coord_t            pt_y_mem [POINT_SLOTS];
  logic [CNT_W-1:0]  cfg_count = 7'd4;
  logic [INV_W-1:0]  cfg_inv_dt = 24'd65536;

  spline_cmd_t       cmd_queue [$];
  curve_sample_t     pending_samples [$];
  spline_cmd_t       on_bus;
  curve_sample_t     want;
  curve_sample_t     got;

  string field_names [4] = '{"pos_x", "pos_y", "vel_x", "vel_y"};

  int error_count    = 0;
  int cycle_count    = 0;
  int writes_taken   = 0;
  int queries_taken  = 0;
  int samples_seen   = 0;
  int settings_used  = 0;
  int burst_left     = 8;
  int gap_left       = 0;
  int stall_left     = 0;
  int stall_mode     = 0;

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int active_segments();
    int n;
    n = int'(cfg_count);
    if (n < MIN_COUNT) n = MIN_COUNT;
    if (n > POINT_SLOTS) n = POINT_SLOTS;
    return n - 3;
  endfunction

  // floor((num + den/2) / den), den > 0
  function automatic longint div_round(input longint num, input longint den);
    longint a;
    longint q;
    a = num + den / 2;
    q = a / den;
    if (a % den != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic coord_t clip32(input longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[31:0];
  endfunction

  function automatic coord_t velocity_of(input longint dsum);
    longint slope;
    slope = div_round(dsum, longint'(2) << FRAC_BITS);
    return clip32(div_round(slope * longint'(cfg_inv_dt), longint'(1) << INV_FRAC));
  endfunction

  function automatic curve_sample_t curve_sample(input logic [U_W-1:0] u_in);
    longint one, segs, uu, tf, t2, t3, seg, cx, cy, px, py, dx, dy;
    longint w [4];
    longint d [4];
    curve_sample_t s;
    one  = longint'(1) << FRAC_BITS;
    segs = active_segments();
    uu   = longint'(u_in);
    // clamp just below the last segment end
    if (uu > segs * one - 1) uu = segs * one - 1;
    seg = uu >> FRAC_BITS;
    tf  = uu & (one - 1);
    t2  = (tf * tf) >> FRAC_BITS;
    t3  = (t2 * tf) >> FRAC_BITS;
    w[0] = one - 3 * tf + 3 * t2 - t3;
    w[1] = 4 * one - 6 * t2 + 3 * t3;
    w[2] = one + 3 * tf + 3 * t2 - 3 * t3;
    w[3] = t3;
    d[0] = -(one - 2 * tf + t2);
    d[1] = 3 * t2 - 4 * tf;
    d[2] = one + 2 * tf - 3 * t2;
    d[3] = t2;
    px = 0; py = 0; dx = 0; dy = 0;
    for (int k = 0; k < 4; k++) begin
      cx = longint'(pt_x_mem[seg + k]);
      cy = longint'(pt_y_mem[seg + k]);
      px += cx * w[k];
      py += cy * w[k];
      dx += cx * d[k];
      dy += cy * d[k];
    end
    s.pos_x = clip32(div_round(px, 6 * one));
    s.pos_y = clip32(div_round(py, 6 * one));
    s.vel_x = velocity_of(dx);
    s.vel_y = velocity_of(dy);
    return s;
  endfunction

  function automatic void apply_transfer(input spline_cmd_t c);
    if (c.cmd == CMD_WRITE) begin
      pt_x_mem[c.slot] = c.x;
      pt_y_mem[c.slot] = c.y;
      writes_taken++;
    end else begin
      pending_samples = {pending_samples, curve_sample(c.u)};
      queries_taken++;
    end
  endfunction

  function automatic coord_t random_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return coord_t'($urandom_range(0, 2000000)) - 32'sd1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [U_W-1:0] random_param(input int segs);
    int one;
    int s;
    one = 1 << FRAC_BITS;
    s   = $urandom_range(0, segs - 1);
    case ($urandom_range(0, 7))
      0: return U_W'($urandom);
      1: return U_W'(s * one);
      2: return U_W'(s * one + one - 1);
      3: return U_W'(segs * one - 1 - $urandom_range(0, 3));
      default: return U_W'($urandom_range(0, segs * one - 1));
    endcase
  endfunction

  // unused fields carry random bits so every input bit but the pad toggles
  function automatic void queue_write(input int slot, input coord_t x, input coord_t y);
    spline_cmd_t c;
    c.cmd  = CMD_WRITE;
    c.slot = IDX_W'(slot);
    c.x    = x;
    c.y    = y;
    c.u    = U_W'($urandom);
    cmd_queue = {cmd_queue, c};
  endfunction

  function automatic void queue_query(input logic [U_W-1:0] u);
    spline_cmd_t c;
    c.cmd  = CMD_EVAL;
    c.slot = IDX_W'($urandom);
    c.x    = $urandom;
    c.y    = $urandom;
    c.u    = u;
    cmd_queue = {cmd_queue, c};
  endfunction

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CONTROL_COUNT) cfg_count = value[CNT_W-1:0];
    else cfg_inv_dt = value[INV_W-1:0];
  endtask

  task automatic set_curve(input int count_val, input int inv_val);
    reg_write(ADDR_CONTROL_COUNT, count_val);
    reg_write(ADDR_INV_DT, inv_val);
    settings_used++;
  endtask

  // hold off until the stream is empty and every sample is back
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || s_tvalid || pending_samples.size() != 0);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic random_phase(input int count_val, input int inv_val, input int n);
    set_curve(count_val, inv_val);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 3)
        queue_write($urandom_range(0, POINT_SLOTS - 1), random_coord(), random_coord());
      else
        queue_query(random_param(active_segments()));
    end
    wait_drained();
  endtask

  // stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 8;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) apply_transfer(on_bus);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || cmd_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          on_bus = cmd_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{PAD_W{1'b0}}, on_bus.u, on_bus.y, on_bus.x, on_bus.slot};
          s_tuser  <= on_bus.cmd;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern: switch between modes every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      2:       m_tready <= (cycle_count % 5 == 0);
      default: m_tready <= ($urandom_range(0, 15) != 0);
    endcase
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_samples.size() == 0) begin
        flag_error($sformatf("output transfer %h with no sample pending", got));
      end else begin
        want = pending_samples.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (got[32*f +: 32] !== want[32*f +: 32])
            flag_error($sformatf("sample %0d %s: expected %h, got %h", samples_seen,
                                 field_names[f], want[32*f +: 32], got[32*f +: 32]));
        end
      end
      samples_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples pending", cycle_count,
               pending_samples.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fill every slot so no query can touch an unwritten point
    queue_write(0, 32'sh7FFFFFFF, 32'sh80000000);
    queue_write(1, 32'sh80000000, 32'sh7FFFFFFF);
    queue_write(2, 32'sh00000000, 32'shFFFFFFFF);
    queue_write(3, 32'sh00010000, 32'shFFFF0000);
    for (int k = 4; k < POINT_SLOTS; k++) queue_write(k, random_coord(), random_coord());

    // reset settings: one segment
    queue_query(22'd0);
    queue_query(22'd1);
    queue_query(22'h00FFFF);
    queue_query(22'h008000);
    queue_query(22'h3FFFFF);
    wait_drained();

    // count below the minimum and a zero time scale
    set_curve(0, 0);
    queue_query(22'h3FFFFF);
    queue_query(22'h008000);
    wait_drained();

    // count past the memory, largest scale, alternating extremes to saturate
    set_curve(127, 24'hFFFFFF);
    queue_write(20, 32'sh7FFFFFFF, 32'sh80000000);
    queue_write(21, 32'sh80000000, 32'sh7FFFFFFF);
    queue_write(22, 32'sh7FFFFFFF, 32'sh80000000);
    queue_write(23, 32'sh80000000, 32'sh7FFFFFFF);
    queue_query(U_W'((20 << FRAC_BITS) + 32'h8000));
    queue_query(U_W'(20 << FRAC_BITS));
    queue_query(U_W'((60 << FRAC_BITS) + 32'hFFFF));
    queue_query(22'h3FFFFF);
    wait_drained();

    set_curve(3, 1);
    queue_query(22'd0);
    queue_query(22'h3FFFFF);
    wait_drained();

    random_phase(64, 65536, 95);
    random_phase(4, $urandom_range(1, 24'hFFFFFF), 95);
    random_phase($urandom_range(5, 63), $urandom_range(1 << 14, 1 << 20), 95);
    random_phase(100, 24'hFFFFFF, 95);
    random_phase(2, 1, 95);
    random_phase($urandom_range(0, 127), $urandom_range(0, 24'hFFFFFF), 95);
    random_phase(64, $urandom_range(1 << 15, 1 << 18), 95);

    $display("Covered %0d point writes and %0d curve queries under %0d register settings,",
             writes_taken, queries_taken, settings_used);
    $display("with %0d output samples checked and %0d mismatches.", samples_seen, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cbe_pkg.sv
hw/rtl/cbe_ram.sv
hw/rtl/cbe_basis.sv
hw/rtl/cbe_axis.sv
hw/rtl/cubic_bspline_evaluator_core.sv
hw/rtl/cbe_checker.sv
test/testbench.sv
